// File: rtl/gcp_pkg.sv
// Shared types and constants for the grid minimum-cost path block.
// Used by grid_min_cost_path; depends on nothing else.
`default_nettype none

package gcp_pkg;

    localparam int CELL_W  = 16;  // cost of one grid cell
    localparam int COST_W  = 22;  // cumulative path cost
    localparam int IDX_W   = 5;   // row or column index
    localparam int CFG_W   = 6;   // size register width
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;
    localparam int OUT_DW  = 2 * IDX_W + COST_W;

    // Register indexes, selected by paddr[2].
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,      // waiting for the next cell word
        S_CALC,      // upper cost is back, write the cumulative cost
        S_TB_WR,     // store the current path cell; off the edges fetch the left cost
        S_TB_RL,     // left cost is back, fetch the upper cost
        S_TB_RU,     // upper cost is back, take one step
        S_OUT_RD,    // read one path cell back
        S_OUT_WAIT   // hand the path cell to the output register
    } t_state;

endpackage

`default_nettype wire

// File: rtl/gcp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
`default_nettype none

module gcp_ram #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 1024
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                       i_wdata,
    input  wire                                    i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/grid_min_cost_path.sv
// Loading takes one table read of the upper cost and one write per cell word.
// After the last cell the traceback steps straight from S_TB_WR along the first row or
// column, elsewhere via S_TB_RL and S_TB_RU (two reads of the one table read port).
// Each path word is read from the path buffer, then waits for a free output register.
// Reset (synchronous, active low) sets both sizes to 32 and restarts loading at (0,0);
// the memories are not cleared, as every entry is written before it is used.
`default_nettype none

module grid_min_cost_path #(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Slave stream: tdata[15:0] = cell_cost.
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire  [gcp_pkg::CELL_W-1:0]   i_s_axis_tdata,
    // Master stream: tdata[4:0] = path_row, [9:5] = path_col, [31:10] = total_cost.
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    output logic [gcp_pkg::OUT_DW-1:0]   o_m_axis_tdata,
    output logic                         o_m_axis_tlast,
    // Configuration port.
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [gcp_pkg::APB_AW-1:0]   paddr,
    input  wire  [gcp_pkg::APB_DW-1:0]   pwdata,
    output logic [gcp_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import gcp_pkg::*;

    localparam int TDEPTH = MAX_ROWS * MAX_COLS;
    localparam int TAW    = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
    localparam int PDEPTH = MAX_ROWS + MAX_COLS - 1;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_grid_rows, r_grid_cols;
    logic [CFG_W-1:0]  eff_rows, eff_cols;
    logic [IDX_W-1:0]  last_row, last_col;

    logic [IDX_W-1:0]  r_row, n_row, r_col, n_col;
    logic [CELL_W-1:0] r_cost, n_cost;
    // Holds the previous cell's cumulative cost while loading, the left cost during traceback.
    logic [COST_W-1:0] r_left, n_left;
    logic [COST_W-1:0] r_total, n_total;
    logic [IDX_W-1:0]  r_tr, n_tr, r_tc, n_tc;
    logic [PAW-1:0]    r_n, n_n, r_k, n_k;

    logic              r_ov, n_ov;
    logic [OUT_DW-1:0] r_odata, n_odata;
    logic              r_olast, n_olast;

    logic              cfg_wr;
    logic              accept;
    logic              out_free;
    logic              cell_last;
    logic [COST_W-1:0] cell_value;
    logic [COST_W-1:0] best;

    logic              t_we, t_re;
    logic [TAW-1:0]    t_waddr, t_raddr;
    logic [COST_W-1:0] t_rdata;

    logic              p_we, p_re;
    logic [2*IDX_W-1:0] p_rdata;

    function automatic logic [TAW-1:0] f_addr(input logic [IDX_W-1:0] row,
                                              input logic [IDX_W-1:0] col);
        return TAW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_ROWS: prdata[CFG_W-1:0] = r_grid_rows;
            REG_COLS: prdata[CFG_W-1:0] = r_grid_cols;
            default:  prdata = '0;
        endcase
    end

    // A size of zero counts as one and sizes clip at the table dimensions.
    always_comb begin
        if (r_grid_rows == '0) begin
            eff_rows = CFG_W'(1);
        end else if (r_grid_rows > CFG_W'(MAX_ROWS)) begin
            eff_rows = CFG_W'(MAX_ROWS);
        end else begin
            eff_rows = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            eff_cols = CFG_W'(1);
        end else if (r_grid_cols > CFG_W'(MAX_COLS)) begin
            eff_cols = CFG_W'(MAX_COLS);
        end else begin
            eff_cols = r_grid_cols;
        end
    end

    assign last_row = IDX_W'(eff_rows - CFG_W'(1));
    assign last_col = IDX_W'(eff_cols - CFG_W'(1));

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ov || i_m_axis_tready;

    // Cumulative cost of the cell being loaded.
    assign best      = (r_left <= t_rdata) ? r_left : t_rdata;
    assign cell_last = (r_row == last_row) && (r_col == last_col);

    always_comb begin
        if (r_row == '0 && r_col == '0) begin
            cell_value = COST_W'(r_cost);
        end else if (r_row == '0) begin
            cell_value = r_left + COST_W'(r_cost);
        end else if (r_col == '0) begin
            cell_value = t_rdata + COST_W'(r_cost);
        end else begin
            cell_value = best + COST_W'(r_cost);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_CALC;
            end
            S_CALC: begin
                n_state = cell_last ? S_TB_WR : S_IDLE;
            end
            S_TB_WR: begin
                if (r_tr == '0 && r_tc == '0) begin
                    n_state = S_OUT_RD;
                end else if (r_tr != '0 && r_tc != '0) begin
                    n_state = S_TB_RL;
                end
            end
            S_TB_RL:    n_state = S_TB_RU;
            S_TB_RU:    n_state = S_TB_WR;
            S_OUT_RD:   n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (out_free) n_state = (r_k == '0) ? S_IDLE : S_OUT_RD;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_cost  = r_cost;
        n_left  = r_left;
        n_total = r_total;
        n_tr    = r_tr;
        n_tc    = r_tc;
        n_n     = r_n;
        n_k     = r_k;
        n_ov    = r_ov && !i_m_axis_tready;
        n_odata = r_odata;
        n_olast = r_olast;
        t_we    = 1'b0;
        t_waddr = f_addr(r_row, r_col);
        t_re    = 1'b0;
        t_raddr = f_addr(r_row - IDX_W'(1), r_col);
        p_we    = 1'b0;
        p_re    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cost = i_s_axis_tdata;
                    t_re   = 1'b1;
                end
            end
            S_CALC: begin
                t_we   = 1'b1;
                n_left = cell_value;
                if (r_col == last_col) begin
                    n_col = '0;
                    n_row = (r_row == last_row) ? '0 : r_row + IDX_W'(1);
                end else begin
                    n_col = r_col + IDX_W'(1);
                end
                if (cell_last) begin
                    n_total = cell_value;
                    n_tr    = last_row;
                    n_tc    = last_col;
                    n_n     = '0;
                end
            end
            S_TB_WR: begin
                p_we    = 1'b1;
                t_raddr = f_addr(r_tr, r_tc - IDX_W'(1));
                if (r_tr == '0 && r_tc == '0) begin
                    n_k = r_n;
                end else begin
                    n_n = r_n + PAW'(1);
                    if (r_tr != '0 && r_tc != '0) begin
                        t_re = 1'b1;
                    end else if (r_tr == '0) begin
                        n_tc = r_tc - IDX_W'(1);
                    end else begin
                        n_tr = r_tr - IDX_W'(1);
                    end
                end
            end
            S_TB_RL: begin
                n_left  = t_rdata;
                t_re    = 1'b1;
                t_raddr = f_addr(r_tr - IDX_W'(1), r_tc);
            end
            S_TB_RU: begin
                // Ties go left.
                if (r_left <= t_rdata) begin
                    n_tc = r_tc - IDX_W'(1);
                end else begin
                    n_tr = r_tr - IDX_W'(1);
                end
            end
            S_OUT_RD: begin
                p_re = 1'b1;
            end
            S_OUT_WAIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_odata = {r_total, p_rdata[IDX_W-1:0], p_rdata[2*IDX_W-1:IDX_W]};
                    n_olast = (r_k == '0);
                    if (r_k != '0) n_k = r_k - PAW'(1);
                end
            end
            default: begin
            end
        endcase

        // Any register write restarts loading at the first cell.
        if (cfg_wr) begin
            n_row = '0;
            n_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_rows <= CFG_W'(32);
            r_grid_cols <= CFG_W'(32);
            r_row       <= '0;
            r_col       <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_ov    <= n_ov;
            if (cfg_wr) begin
                case (paddr[2])
                    REG_ROWS: r_grid_rows <= pwdata[CFG_W-1:0];
                    REG_COLS: r_grid_cols <= pwdata[CFG_W-1:0];
                    default:  r_grid_rows <= r_grid_rows;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cost  <= n_cost;
        r_left  <= n_left;
        r_total <= n_total;
        r_tr    <= n_tr;
        r_tc    <= n_tc;
        r_n     <= n_n;
        r_k     <= n_k;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    gcp_ram #(
        .WIDTH (COST_W),
        .DEPTH (TDEPTH)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (cell_value),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    // Path cells are stored corner first as {row, col} and read back in reverse.
    gcp_ram #(
        .WIDTH (2 * IDX_W),
        .DEPTH (PDEPTH)
    ) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (r_n),
        .i_wdata ({r_tr, r_tc}),
        .i_re    (p_re),
        .i_raddr (r_k),
        .o_rdata (p_rdata)
    );

endmodule

`default_nettype wire
